[rtl/core/shortest_queue_dispatcher_macros.svh]
// Assertion macros for the shortest queue dispatcher
`ifndef SHORTEST_QUEUE_DISPATCHER_MACROS_SVH
`define SHORTEST_QUEUE_DISPATCHER_MACROS_SVH
// Assert an implication on the next clock edge, off during reset
`define SQD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sqd check failed");
// Assert an implication in the same cycle, off during reset
`define SQD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sqd check failed");
`endif

[rtl/core/sqd_pkg.sv]
// Shared types for the shortest queue dispatcher
`default_nettype none
package sqd_pkg;
    localparam int unsigned ST_W   = 16;
    localparam int unsigned ID_W   = 10;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned WIN_W  = 4;

    typedef struct packed {
        logic            op;
        logic [ST_W-1:0] service_time;
    } sqd_in_t;

    typedef struct packed {
        logic              status;
        logic [WIN_W-1:0]  window;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] finish_time;
        logic              last;
    } sqd_out_t;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_DROP = 1'b1;
endpackage
`default_nettype wire

[rtl/core/shortest_queue_dispatcher.sv]
// Join shortest queue dispatcher top level
// Channel | Direction | Payload
// s_      | in        | sqd_in_t: op, service_time
// m_      | out       | sqd_out_t: status, window, job_id, finish_time, last
// cfg_    | in        | active_windows (4 bits)
// A tick accepts a job, scans the queue lengths of the active windows, enqueues,
// then for each window skips it if empty or reads its head and serves it, and
// finally flushes the pending beat. A serve step or the flush waits while the
// result register is full and not taken; input waits for it to empty.
// aresetn is synchronous, active low; lengths, heads, tick and id counters clear.
// The ring memory holds no reset; slots are read only after being written.
`default_nettype none
module shortest_queue_dispatcher #(
    parameter int unsigned NUM_WINDOWS = 8,
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sqd_pkg::sqd_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sqd_pkg::sqd_out_t      m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [3:0]        cfg_data
);
    import sqd_pkg::*;
`include "shortest_queue_dispatcher_macros.svh"

    localparam int unsigned WI_W  = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned LEN_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ADDR_W = WI_W + PTR_W;
    localparam int unsigned CNT_W = $clog2(NUM_WINDOWS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_ENQ, S_READ, S_WAIT, S_SERVE
    } state_t;

    state_t state_reg;
    logic [3:0] active_reg;
    logic [LEN_W-1:0] len_reg [NUM_WINDOWS];
    logic [PTR_W-1:0] head_reg [NUM_WINDOWS];
    logic [TIME_W-1:0] tick_reg;
    logic [ID_W-1:0] next_id_reg;
    logic [ST_W-1:0] st_reg;
    logic [ID_W-1:0] id_reg;
    logic arrive_reg;
    logic [WI_W-1:0] idx_reg;
    logic [WI_W-1:0] best_reg;
    logic found_reg;
    logic [CNT_W-1:0] used_reg;
    logic pend_reg;
    sqd_out_t pend_data_reg;
    logic out_valid_reg;
    sqd_out_t out_data_reg;

    logic wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [ID_W+ST_W-1:0] wr_data, rd_data;
    logic [ST_W-1:0] rem, rem_dec;
    logic [ID_W-1:0] rid;
    logic out_free;
    logic out_load;
    logic [CNT_W-1:0] used_w;
    logic [PTR_W-1:0] tail_pos;
    logic idx_last;

    sqd_queue_ram #(.ADDR_W(ADDR_W)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Clamp the window count to one through NUM_WINDOWS
    always_comb begin
        if (active_reg == 4'd0) begin
            used_w = CNT_W'(1);
        end else if ({28'd0, active_reg} > NUM_WINDOWS) begin
            used_w = CNT_W'(NUM_WINDOWS);
        end else begin
            used_w = CNT_W'(active_reg);
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign out_load = out_free && pend_reg &&
                      ((state_reg == S_SERVE && rem_dec == '0) || state_reg == S_WAIT);
    assign {rid, rem} = rd_data;
    assign rem_dec = (rem > ST_W'(1)) ? rem - ST_W'(1) : '0;
    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) >= used_reg;
    assign tail_pos = PTR_W'((LEN_W+1)'(head_reg[best_reg]) + (LEN_W+1)'(len_reg[best_reg])
                      - ((LEN_W+1)'(head_reg[best_reg]) + (LEN_W+1)'(len_reg[best_reg])
                         >= (LEN_W+1)'(QUEUE_DEPTH) ? (LEN_W+1)'(QUEUE_DEPTH) : '0));

    // Memory port steering
    always_comb begin
        rd_addr = {idx_reg, head_reg[idx_reg]};
        wr_en   = 1'b0;
        wr_addr = {idx_reg, head_reg[idx_reg]};
        wr_data = {rid, rem_dec};
        if (state_reg == S_ENQ) begin
            wr_en   = found_reg && arrive_reg;
            wr_addr = {best_reg, tail_pos};
            wr_data = {id_reg, (st_reg == '0) ? ST_W'(1) : st_reg};
        end else if (state_reg == S_SERVE && out_free) begin
            wr_en = (rem_dec != '0);
        end
    end

    assign s_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Tick sequencer: scan, enqueue, then read and serve each window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            active_reg    <= 4'd8;
            tick_reg      <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                len_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end else begin
            // Load a result beat or drop the one taken
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cfg_valid) begin
                        active_reg <= cfg_data;
                    end
                    if (s_valid && s_ready) begin
                        arrive_reg  <= s_data.op;
                        st_reg      <= s_data.service_time;
                        id_reg      <= next_id_reg;
                        if (s_data.op) begin
                            next_id_reg <= next_id_reg + ID_W'(1);
                        end
                        used_reg  <= used_w;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Keep the first shortest queue that has room
                    if (len_reg[idx_reg] < LEN_W'(QUEUE_DEPTH) &&
                        (!found_reg || len_reg[idx_reg] < len_reg[best_reg])) begin
                        best_reg  <= idx_reg;
                        found_reg <= 1'b1;
                    end
                    if (idx_last) begin
                        state_reg <= S_ENQ;
                    end else begin
                        idx_reg <= idx_reg + WI_W'(1);
                    end
                end
                S_ENQ: begin
                    tick_reg <= tick_reg + TIME_W'(1);
                    if (arrive_reg && found_reg) begin
                        len_reg[best_reg] <= len_reg[best_reg] + LEN_W'(1);
                    end
                    pend_reg <= arrive_reg && !found_reg;
                    pend_data_reg.status      <= STATUS_DROP;
                    pend_data_reg.window      <= '0;
                    pend_data_reg.job_id      <= id_reg;
                    pend_data_reg.finish_time <= tick_reg + TIME_W'(1);
                    pend_data_reg.last        <= 1'b0;
                    idx_reg   <= '0;
                    state_reg <= S_READ;
                end
                S_READ: begin
                    // Skip empty windows; else issue the head read
                    if (len_reg[idx_reg] == '0) begin
                        if (idx_last) begin
                            state_reg <= S_WAIT;
                        end else begin
                            idx_reg <= idx_reg + WI_W'(1);
                        end
                    end else begin
                        state_reg <= S_SERVE;
                    end
                end
                S_SERVE: begin
                    // Decrement the head; hold a finish as the pending beat
                    if (out_free) begin
                        if (rem_dec == '0) begin
                            if (pend_reg) begin
                                out_data_reg <= pend_data_reg;
                            end
                            pend_reg <= 1'b1;
                            pend_data_reg.status      <= STATUS_DONE;
                            pend_data_reg.window      <= WIN_W'(idx_reg) + WIN_W'(1);
                            pend_data_reg.job_id      <= rid;
                            pend_data_reg.finish_time <= tick_reg;
                            pend_data_reg.last        <= 1'b0;
                            head_reg[idx_reg] <= (head_reg[idx_reg] == PTR_W'(QUEUE_DEPTH - 1))
                                                 ? '0 : head_reg[idx_reg] + PTR_W'(1);
                            len_reg[idx_reg]  <= len_reg[idx_reg] - LEN_W'(1);
                        end
                        if (idx_last) begin
                            state_reg <= S_WAIT;
                        end else begin
                            idx_reg   <= idx_reg + WI_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_WAIT: begin
                    // Flush the pending beat marked last
                    if (!pend_reg) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        out_data_reg <= '{status: pend_data_reg.status,
                                          window: pend_data_reg.window,
                                          job_id: pend_data_reg.job_id,
                                          finish_time: pend_data_reg.finish_time,
                                          last: 1'b1};
                        pend_reg     <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SQD_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `SQD_ASSERT_NOW(a_drop_window, aclk, aresetn, m_valid && m_data.status == STATUS_DROP, m_data.window == '0)
    `SQD_ASSERT_NOW(a_no_input_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready)
endmodule
`default_nettype wire

[rtl/core/sqd_queue_ram.sv]
// Job ring storage: id and remaining time per slot, one read and one write port
`default_nettype none
module sqd_queue_ram #(
    parameter int unsigned ADDR_W = 9
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [ADDR_W-1:0]         wr_addr,
    input  wire logic [sqd_pkg::ID_W+sqd_pkg::ST_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]         rd_addr,
    output logic [sqd_pkg::ID_W+sqd_pkg::ST_W-1:0]      rd_data
);
    import sqd_pkg::*;
    logic [ID_W+ST_W-1:0] mem [2**ADDR_W];

    // Write, then registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire
